[rtl/core/sda_pkg.sv]
// Shared types and constants of the segment download allocator.
// Holds the payload structs, the operation and state codes and the reset values.
// No dependencies.
`default_nettype none

package sda_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned MAX_SEGMENTS_DEF = 1024;
  localparam int unsigned FIELD_W          = 11;
  localparam int unsigned PCT_W            = 7;
  localparam int unsigned PCT_SCALE        = 100;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 1'b1;
  localparam logic [FIELD_W-1:0] SEG_COUNT_RST = 11'd1024;
  localparam logic [FIELD_W-1:0] MAX_CHUNK_RST = 11'd16;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_FILL     = 2'd3
  } sda_op_e;

  // Per-segment states held in the table.
  typedef enum logic [1:0] {
    SEG_MISSING = 2'd0,
    SEG_BUSY    = 2'd1,
    SEG_PRESENT = 2'd2
  } sda_seg_e;

  // Datapath walker modes.
  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_SWEEP = 3'd1,
    MODE_MARK  = 3'd2,
    MODE_ALLOC = 3'd3,
    MODE_COUNT = 3'd4
  } sda_mode_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'd0,
    ST_IDLE  = 4'd1,
    ST_START = 4'd2,
    ST_SWEEP = 4'd3,
    ST_MARK  = 4'd4,
    ST_ALLOC = 4'd5,
    ST_COUNT = 4'd6,
    ST_DIV   = 4'd7,
    ST_DONE  = 4'd8
  } sda_state_e;

  // Input and output payloads.
  typedef struct packed {
    sda_op_e            op;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_end;
    logic               fill_present;
  } sda_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_start;
    logic [FIELD_W-1:0] alloc_end;
    logic               all_present;
    logic [PCT_W-1:0]   present_percent;
  } sda_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    sda_mode_e mode;
    logic      init;
    logic      init_lo;
    logic      clear;
    logic      load;
    logic      div_start;
    logic      capture;
  } sda_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    sda_op_e op;
    logic    mark_empty;
    logic    walk_done;
  } sda_stat_t;

endpackage

`default_nettype wire

[rtl/core/segment_download_allocator.sv]
// Top level of the segment download allocator.
// Instantiates sda_ctrl, sda_datapath and sda_div. Depends on sda_pkg.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_stall_o   in_data_i   (sda_in_t)
//   out      source     out_valid_o/out_stall_i out_data_o  (sda_out_t)
//   cfg      sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item at a time. Each accepted item walks the dual-port table for its operation,
// walks the tracked entries again to count the present ones and then runs the bit-serial
// divider before its result is captured. Allocate walks the tracked entries until its run
// ends, release and complete walk the clipped range, and fill walks the whole table.
// After reset a clearing pass over the whole table runs before the first beat is taken.
// A finished result waits in the output register, so a stalled output only holds the
// next item at its final step.
`default_nettype none

module segment_download_allocator #(
  parameter int unsigned MAX_SEGMENTS = sda_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sda_pkg::sda_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sda_pkg::sda_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sda_pkg::FIELD_W-1:0]   cfg_wdata_i
);

  localparam int unsigned NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned NUM_W = NW + sda_pkg::PCT_W;

  sda_pkg::sda_cmd_t  cmd;
  sda_pkg::sda_stat_t stat;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quo;
  logic [NW-1:0]      div_den;

  sda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  sda_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .NUM_W        (NUM_W),
    .NW           (NW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_quo_i   (div_quo),
    .out_data_o  (out_data_o)
  );

  sda_div #(
    .NUM_W (NUM_W),
    .DEN_W (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule

`default_nettype wire

[rtl/core/sda_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used for the present percentage. Depends on no package.
`default_nettype none

module sda_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_ext;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_ext = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_ext - {1'b0, den_q};
    ge      = rem_ext >= {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_ext[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[rtl/core/sda_ctrl.sv]
// Controller state machine of the segment download allocator.
// Sequences the table walks and the divide. Depends on sda_pkg.
`default_nettype none

module sda_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire sda_pkg::sda_stat_t stat_i,
  input  wire logic              div_done_i,
  output sda_pkg::sda_cmd_t      cmd_o
);

  sda_pkg::sda_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // State register and output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sda_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sda_pkg::ST_CLEAR: begin
        cmd_o.mode  = sda_pkg::MODE_SWEEP;
        cmd_o.clear = 1'b1;
        if (stat_i.walk_done) begin
          state_d = sda_pkg::ST_IDLE;
        end
      end
      sda_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sda_pkg::ST_START;
        end
      end
      sda_pkg::ST_START: begin
        cmd_o.init = 1'b1;
        case (stat_i.op)
          sda_pkg::OP_ALLOC: begin
            state_d = sda_pkg::ST_ALLOC;
          end
          sda_pkg::OP_RELEASE, sda_pkg::OP_COMPLETE: begin
            if (stat_i.mark_empty) begin
              state_d = sda_pkg::ST_COUNT;
            end else begin
              cmd_o.init_lo = 1'b1;
              state_d       = sda_pkg::ST_MARK;
            end
          end
          sda_pkg::OP_FILL: begin
            state_d = sda_pkg::ST_SWEEP;
          end
          default: begin
            state_d = sda_pkg::ST_COUNT;
          end
        endcase
      end
      sda_pkg::ST_SWEEP: begin
        cmd_o.mode = sda_pkg::MODE_SWEEP;
        if (stat_i.walk_done) begin
          cmd_o.init = 1'b1;
          state_d    = sda_pkg::ST_COUNT;
        end
      end
      sda_pkg::ST_MARK: begin
        cmd_o.mode = sda_pkg::MODE_MARK;
        if (stat_i.walk_done) begin
          cmd_o.init = 1'b1;
          state_d    = sda_pkg::ST_COUNT;
        end
      end
      sda_pkg::ST_ALLOC: begin
        cmd_o.mode = sda_pkg::MODE_ALLOC;
        if (stat_i.walk_done) begin
          cmd_o.init = 1'b1;
          state_d    = sda_pkg::ST_COUNT;
        end
      end
      sda_pkg::ST_COUNT: begin
        cmd_o.mode = sda_pkg::MODE_COUNT;
        if (stat_i.walk_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = sda_pkg::ST_DIV;
        end
      end
      sda_pkg::ST_DIV: begin
        if (div_done_i) begin
          state_d = sda_pkg::ST_DONE;
        end
      end
      sda_pkg::ST_DONE: begin
        // Load the output register once the previous result has left.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sda_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid is set on capture and cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = state_q != sda_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/sda_datapath.sv]
// Datapath of the segment download allocator: segment table memory, walker,
// allocation run tracking, present counter, configuration and result registers.
// Depends on sda_pkg.
`default_nettype none

module sda_datapath #(
  parameter int unsigned MAX_SEGMENTS = sda_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned NUM_W        = 18,
  parameter int unsigned NW           = 11
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sda_pkg::sda_cmd_t                cmd_i,
  output sda_pkg::sda_stat_t                    stat_o,
  input  wire sda_pkg::sda_in_t                 in_data_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [sda_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sda_pkg::FIELD_W-1:0]      cfg_wdata_i,
  output logic [NUM_W-1:0]                      div_num_o,
  output logic [NW-1:0]                         div_den_o,
  input  wire logic [NUM_W-1:0]                 div_quo_i,
  output sda_pkg::sda_out_t                     out_data_o
);

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = (NW > sda_pkg::FIELD_W) ? NW : sda_pkg::FIELD_W;

  logic [1:0] mem [MAX_SEGMENTS];

  logic [sda_pkg::FIELD_W-1:0] seg_count_q, max_chunk_q;
  sda_pkg::sda_in_t            item_q;
  sda_pkg::sda_out_t           res_q;

  logic [NW-1:0] idx_q, idx_d;
  logic [NW-1:0] ridx_q;
  logic [1:0]    rdata_q;
  logic          rvld_q, rvld_d;
  logic          found_q, found_d;
  logic          stop_q, stop_d;
  logic [NW-1:0] s_q, s_d;
  logic [NW-1:0] e_q, e_d;
  logic [NW-1:0] cnt_q, cnt_d;

  logic [CW-1:0] seg_ext, n_cw, rs_c, re_c, a_cw, b_cw, cap_cw, run_cw;
  logic [NW-1:0] n_w, a_w, b_w;
  logic          issue, proc, is_miss, run_ok, take, stop_set;
  logic          we;
  logic [1:0]    wdata;
  logic [NW-1:0] waddr;

  // Tracked segment count, clipped range bounds and chunk cap.
  always_comb begin
    seg_ext = CW'(seg_count_q);
    if (seg_ext > CW'(MAX_SEGMENTS)) begin
      n_cw = CW'(MAX_SEGMENTS);
    end else if (seg_count_q == '0) begin
      n_cw = CW'(1);
    end else begin
      n_cw = seg_ext;
    end
    n_w    = n_cw[NW-1:0];
    rs_c   = CW'(item_q.range_start);
    re_c   = CW'(item_q.range_end);
    a_cw   = (rs_c > n_cw) ? n_cw : rs_c;
    b_cw   = (re_c > n_cw) ? n_cw : re_c;
    a_w    = a_cw[NW-1:0];
    b_w    = b_cw[NW-1:0];
    cap_cw = (max_chunk_q == '0) ? CW'(1) : CW'(max_chunk_q);
    run_cw = CW'(e_q) - CW'(s_q);
  end

  // Allocation run decisions on the registered read data.
  always_comb begin
    issue    = ((cmd_i.mode == sda_pkg::MODE_ALLOC) || (cmd_i.mode == sda_pkg::MODE_COUNT))
               && !stop_q && (idx_q < n_w);
    proc     = rvld_q && !stop_q && (cmd_i.mode == sda_pkg::MODE_ALLOC);
    is_miss  = rdata_q == sda_pkg::SEG_MISSING;
    run_ok   = run_cw < cap_cw;
    take     = proc && is_miss && (!found_q || run_ok);
    stop_set = proc && found_q && !(is_miss && run_ok);
  end

  // Table write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = sda_pkg::SEG_MISSING;
    case (cmd_i.mode)
      sda_pkg::MODE_SWEEP: begin
        we    = 1'b1;
        wdata = (!cmd_i.clear && item_q.fill_present) ? sda_pkg::SEG_PRESENT
                                                      : sda_pkg::SEG_MISSING;
      end
      sda_pkg::MODE_MARK: begin
        we    = 1'b1;
        wdata = (item_q.op == sda_pkg::OP_RELEASE) ? sda_pkg::SEG_MISSING
                                                   : sda_pkg::SEG_PRESENT;
      end
      sda_pkg::MODE_ALLOC: begin
        we    = take;
        waddr = ridx_q;
        wdata = sda_pkg::SEG_BUSY;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Walker, run and counter next values.
  always_comb begin
    idx_d   = idx_q;
    rvld_d  = issue;
    found_d = found_q;
    stop_d  = stop_q;
    s_d     = s_q;
    e_d     = e_q;
    cnt_d   = cnt_q;
    if ((cmd_i.mode == sda_pkg::MODE_SWEEP) || (cmd_i.mode == sda_pkg::MODE_MARK) || issue) begin
      idx_d = idx_q + NW'(1);
    end
    if (take) begin
      found_d = 1'b1;
      e_d     = ridx_q + NW'(1);
      if (!found_q) begin
        s_d = ridx_q;
      end
    end
    if (stop_set) begin
      stop_d = 1'b1;
    end
    if ((cmd_i.mode == sda_pkg::MODE_COUNT) && rvld_q && (rdata_q == sda_pkg::SEG_PRESENT)) begin
      cnt_d = cnt_q + NW'(1);
    end
    if (cmd_i.init) begin
      idx_d  = cmd_i.init_lo ? a_w : '0;
      rvld_d = 1'b0;
      stop_d = 1'b0;
      cnt_d  = '0;
    end
    if (cmd_i.load) begin
      found_d = 1'b0;
      stop_d  = 1'b0;
    end
  end

  // Walk completion for the active mode.
  always_comb begin
    stat_o.op         = item_q.op;
    stat_o.mark_empty = a_cw >= b_cw;
    case (cmd_i.mode)
      sda_pkg::MODE_SWEEP: stat_o.walk_done = idx_q == NW'(MAX_SEGMENTS - 1);
      sda_pkg::MODE_MARK:  stat_o.walk_done = (idx_q + NW'(1)) == b_w;
      sda_pkg::MODE_ALLOC,
      sda_pkg::MODE_COUNT: stat_o.walk_done = stop_q || ((idx_q >= n_w) && !rvld_q);
      default:             stat_o.walk_done = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= sda_pkg::SEG_COUNT_RST;
      max_chunk_q <= sda_pkg::MAX_CHUNK_RST;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sda_pkg::CFG_SEG_COUNT: seg_count_q <= cfg_wdata_i;
          sda_pkg::CFG_MAX_CHUNK: max_chunk_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      idx_q   <= idx_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      stop_q  <= stop_d;
      cnt_q   <= cnt_d;
    end
  end

  // Segment table with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[idx_q[AW-1:0]];
      ridx_q  <= idx_q;
    end
  end

  // Payload registers: item, run bounds and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    s_q <= s_d;
    e_q <= e_d;
    if (cmd_i.capture) begin
      res_q.alloc_start     <= ((item_q.op == sda_pkg::OP_ALLOC) && found_q)
                               ? sda_pkg::FIELD_W'(s_q) : '0;
      res_q.alloc_end       <= ((item_q.op == sda_pkg::OP_ALLOC) && found_q)
                               ? sda_pkg::FIELD_W'(e_q) : '0;
      res_q.all_present     <= cnt_q == n_w;
      res_q.present_percent <= div_quo_i[sda_pkg::PCT_W-1:0];
    end
  end

  // Divider operands: present count scaled to percent over tracked count.
  assign div_num_o  = NUM_W'(cnt_q) * NUM_W'(sda_pkg::PCT_SCALE);
  assign div_den_o  = n_w;
  assign out_data_o = res_q;

endmodule

`default_nettype wire

[rtl/core/sda_checker.sv]
// Port-level checks of the segment download allocator and their bind.
// Depends on sda_pkg and segment_download_allocator.
`default_nettype none

module sda_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire sda_pkg::sda_out_t out_data_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The percentage never passes one hundred.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.present_percent <= sda_pkg::PCT_W'(sda_pkg::PCT_SCALE))
    else $error("present percentage out of range");

  // A complete file reports one hundred percent.
  a_all_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.all_present
    |-> out_data_o.present_percent == sda_pkg::PCT_W'(sda_pkg::PCT_SCALE))
    else $error("all present without full percentage");

  // An allocated range never runs backward.
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.alloc_start <= out_data_o.alloc_end)
    else $error("allocated range start beyond its end");

endmodule

bind segment_download_allocator sda_checker u_sda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[verif/sda_checker.sv]
// Scoreboard for the segment download allocator: watches the in, out and cfg channels,
// predicts every result from its own copy of the segment table and compares.
// Depends on sda_pkg.
`timescale 1ns / 1ps

module sda_scoreboard #(
  parameter int unsigned MAX_SEGMENTS = sda_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  sda_pkg::sda_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  sda_pkg::sda_out_t             out_data_i,
  input  logic                          cfg_we_i,
  input  logic [sda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sda_pkg::FIELD_W-1:0]   cfg_wdata_i,
  output int                            fail_count_o,
  output int                            results_seen_o,
  output int                            pending_o
);

  // Shadow of the segment table and the two registers.
  sda_pkg::sda_seg_e           seg_state [MAX_SEGMENTS];
  logic [sda_pkg::FIELD_W-1:0] seg_count_q;
  logic [sda_pkg::FIELD_W-1:0] chunk_q;

  // Results still owed by the block, oldest first.
  sda_pkg::sda_out_t expected_q [$];
  int                mismatches = 0;
  int                checked    = 0;

  // Applies one operation to the shadow table and works out the result it produces.
  task automatic apply_segment_op(input sda_pkg::sda_in_t beat,
                                  output sda_pkg::sda_out_t res);
    int tracked_n;
    int cap;
    int lo;
    int hi;
    int first_free;
    int run_end;
    int present;
    tracked_n = (seg_count_q > MAX_SEGMENTS) ? MAX_SEGMENTS :
                (seg_count_q == 0) ? 1 : int'(seg_count_q);
    res = '0;
    case (beat.op)
      sda_pkg::OP_ALLOC: begin
        cap = (chunk_q == 0) ? 1 : int'(chunk_q);
        first_free = -1;
        for (int i = 0; i < tracked_n; i++) begin
          if (seg_state[i] == sda_pkg::SEG_MISSING) begin
            first_free = i;
            break;
          end
        end
        // The run stops at the first non-missing entry, the tracked end or the cap.
        if (first_free >= 0) begin
          run_end = first_free + 1;
          while (run_end < tracked_n && seg_state[run_end] == sda_pkg::SEG_MISSING &&
                 run_end - first_free < cap) begin
            run_end++;
          end
          for (int i = first_free; i < run_end; i++) seg_state[i] = sda_pkg::SEG_BUSY;
          res.alloc_start = sda_pkg::FIELD_W'(first_free);
          res.alloc_end   = sda_pkg::FIELD_W'(run_end);
        end
      end
      sda_pkg::OP_RELEASE, sda_pkg::OP_COMPLETE: begin
        lo = (beat.range_start > tracked_n) ? tracked_n : int'(beat.range_start);
        hi = (beat.range_end > tracked_n) ? tracked_n : int'(beat.range_end);
        for (int i = lo; i < hi; i++) begin
          seg_state[i] = (beat.op == sda_pkg::OP_RELEASE) ? sda_pkg::SEG_MISSING
                                                          : sda_pkg::SEG_PRESENT;
        end
      end
      default: begin
        // Fill touches the whole table, untracked entries too.
        foreach (seg_state[i]) begin
          seg_state[i] = beat.fill_present ? sda_pkg::SEG_PRESENT : sda_pkg::SEG_MISSING;
        end
      end
    endcase
    present = 0;
    for (int i = 0; i < tracked_n; i++) begin
      if (seg_state[i] == sda_pkg::SEG_PRESENT) present++;
    end
    res.all_present     = (present == tracked_n);
    res.present_percent = sda_pkg::PCT_W'((present * sda_pkg::PCT_SCALE) / tracked_n);
  endtask

  // Only the first few mismatches are printed; all of them are counted.
  task automatic report_mismatch(input sda_pkg::sda_out_t want,
                                 input sda_pkg::sda_out_t got);
    if (mismatches < 10) begin
      $display("%0t: result %0d mismatch: expected start=%0d end=%0d full=%0b pct=%0d",
               $time, checked, want.alloc_start, want.alloc_end, want.all_present,
               want.present_percent);
      $display("%0t:   got start=%0d end=%0d full=%0b pct=%0d", $time, got.alloc_start,
               got.alloc_end, got.all_present, got.present_percent);
    end
    mismatches++;
  endtask

  // Results are checked before a new beat is predicted; with one item in flight
  // an outgoing beat never belongs to an input taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    sda_pkg::sda_out_t predicted;
    sda_pkg::sda_out_t oldest;
    if (!rst_ni) begin
      foreach (seg_state[i]) seg_state[i] = sda_pkg::SEG_MISSING;
      seg_count_q = sda_pkg::SEG_COUNT_RST;
      chunk_q     = sda_pkg::MAX_CHUNK_RST;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result %0d arrived with nothing expected (start=%0d end=%0d)",
                     $time, checked, out_data_i.alloc_start, out_data_i.alloc_end);
          end
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          if (out_data_i.alloc_start !== oldest.alloc_start ||
              out_data_i.alloc_end !== oldest.alloc_end ||
              out_data_i.all_present !== oldest.all_present ||
              out_data_i.present_percent !== oldest.present_percent) begin
            report_mismatch(oldest, out_data_i);
          end
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        apply_segment_op(in_data_i, predicted);
        expected_q = {expected_q, predicted};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sda_pkg::CFG_SEG_COUNT: seg_count_q = cfg_wdata_i;
          sda_pkg::CFG_MAX_CHUNK: chunk_q     = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    fail_count_o   <= mismatches;
    results_seen_o <= checked;
    pending_o      <= expected_q.size();
  end

endmodule

[verif/tb_segment_download_allocator.sv]
// Top of the segment download allocator testbench: clock, reset, stimulus and verdict.
// Instantiates segment_download_allocator and sda_scoreboard; depends on sda_pkg.
`timescale 1ns / 1ps

module tb_segment_download_allocator;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int TAIL_CYCLES     = 2200;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  sda_pkg::sda_in_t              in_data_i   = '0;
  logic                          out_stall_i = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [sda_pkg::CFG_IDX_W-1:0] cfg_idx_i   = sda_pkg::CFG_SEG_COUNT;
  logic [sda_pkg::FIELD_W-1:0]   cfg_wdata_i = '0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  sda_pkg::sda_out_t             out_data_o;

  int fail_count;
  int results_seen;
  int pending;

  // Stimulus bookkeeping.
  int beats_sent = 0;
  int next_gap   = 0;
  int n_tracked  = 1024;
  int stall_left = 0;
  bit valid_up   = 1'b0;
  bit no_idle    = 1'b0;

  segment_download_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  sda_scoreboard u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .results_seen_o(results_seen),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit well above the slowest legal run.
  initial begin
    #60_000_000;
    $display("FAIL segment_download_allocator");
    $finish;
  end

  // Result side: after every taken beat, hold stall high for a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    int hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      hold = no_idle ? 0 : $urandom_range(0, 14);
      stall_left  <= hold;
      out_stall_i <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  function automatic sda_pkg::sda_in_t make_beat(sda_pkg::sda_op_e op, int rs, int re,
                                                 bit fp);
    sda_pkg::sda_in_t b;
    b.op           = op;
    b.range_start  = sda_pkg::FIELD_W'(rs);
    b.range_end    = sda_pkg::FIELD_W'(re);
    b.fill_present = fp;
    return b;
  endfunction

  // Random operation: mostly allocations and in-range marking, some fills,
  // empty or reversed ranges, and a share of fully random beats.
  function automatic sda_pkg::sda_in_t pick_segment_op();
    sda_pkg::sda_in_t b;
    int               roll;
    int               shape;
    int               lo;
    b     = sda_pkg::sda_in_t'($bits(sda_pkg::sda_in_t)'($urandom));
    roll  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (roll < 10) return b;
    if (roll < 45) b.op = sda_pkg::OP_ALLOC;
    else if (roll < 70) b.op = sda_pkg::OP_COMPLETE;
    else if (roll < 88) b.op = sda_pkg::OP_RELEASE;
    else if (roll < 94) begin
      b.op          = sda_pkg::OP_COMPLETE;
      b.range_start = '0;
      b.range_end   = shape[0] ? sda_pkg::FIELD_W'(n_tracked) : '1;
      return b;
    end else begin
      b.op = sda_pkg::OP_FILL;
      return b;
    end
    // Range inside the tracked segments, else reversed, else left random.
    if (shape >= 2) begin
      lo            = $urandom_range(0, n_tracked - 1);
      b.range_start = sda_pkg::FIELD_W'(lo);
      b.range_end   = sda_pkg::FIELD_W'($urandom_range(lo + 1, n_tracked));
    end else if (shape == 1) begin
      lo            = $urandom_range(1, n_tracked);
      b.range_start = sda_pkg::FIELD_W'(lo);
      b.range_end   = sda_pkg::FIELD_W'($urandom_range(0, lo));
    end
    return b;
  endfunction

  // Offers one beat after the gap drawn at the previous acceptance.
  task automatic send_beat(input sda_pkg::sda_in_t b);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    next_gap = no_idle ? 0 : $urandom_range(0, 14);
    if (next_gap != 0) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic drain_results();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk_i);
    while (results_seen != beats_sent) @(posedge clk_i);
  endtask

  // Writes the segment count register, then the chunk register; only called with the block idle.
  task automatic set_registers(input logic [sda_pkg::FIELD_W-1:0] seg_count,
                               input logic [sda_pkg::FIELD_W-1:0] chunk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sda_pkg::CFG_SEG_COUNT;
    cfg_wdata_i <= seg_count;
    @(posedge clk_i);
    cfg_idx_i   <= sda_pkg::CFG_MAX_CHUNK;
    cfg_wdata_i <= chunk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_tracked = (seg_count > 1024) ? 1024 : (seg_count == 0) ? 1 : int'(seg_count);
  endtask

  initial begin
    logic [sda_pkg::FIELD_W-1:0] seg_cfg;
    logic [sda_pkg::FIELD_W-1:0] chunk_cfg;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset settings: 1024 segments, chunks of 16.
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_ALLOC, 2047, 2047, 1));
    send_beat(make_beat(sda_pkg::OP_COMPLETE, 0, 16, 0));
    // Release overrides present entries, and the next run stops at a present one.
    send_beat(make_beat(sda_pkg::OP_RELEASE, 8, 12, 0));
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_COMPLETE, 2047, 2047, 0));
    send_beat(make_beat(sda_pkg::OP_COMPLETE, 100, 50, 0));
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_RELEASE, 0, 2047, 0));
    send_beat(make_beat(sda_pkg::OP_COMPLETE, 0, 2047, 1));
    // Nothing missing, then a single missing segment at the very end.
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_RELEASE, 1023, 1024, 0));
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_COMPLETE, 1023, 1024, 0));
    send_beat(make_beat(sda_pkg::OP_RELEASE, 0, 1, 0));
    send_beat(make_beat(sda_pkg::OP_FILL, 'h555, 'h2AA, 0));
    send_beat(make_beat(sda_pkg::OP_FILL, 'h2AA, 'h555, 1));
    send_beat(make_beat(sda_pkg::OP_RELEASE, 'h400, 'h7FF, 0));
    send_beat(make_beat(sda_pkg::OP_RELEASE, 5, 1029, 0));
    send_beat(make_beat(sda_pkg::OP_FILL, 0, 0, 0));
    send_beat(make_beat(sda_pkg::OP_ALLOC, 0, 0, 0));
    drain_results();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin seg_cfg = 0; chunk_cfg = 0; end
        1: begin seg_cfg = '1; chunk_cfg = '1; end
        2: begin seg_cfg = 1; chunk_cfg = 1024; end
        3: begin seg_cfg = 37; chunk_cfg = 0; end
        4: begin seg_cfg = 1024; chunk_cfg = 1; end
        5: begin seg_cfg = 1023; chunk_cfg = 1024; end
        default: begin
          seg_cfg   = sda_pkg::FIELD_W'($urandom_range(2, 64));
          chunk_cfg = sda_pkg::FIELD_W'($urandom_range(1, 24));
        end
      endcase
      set_registers(seg_cfg, chunk_cfg);
      no_idle = (phase % 4 == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_beat(pick_segment_op());
        if ($urandom_range(0, 49) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d beats over %0d register settings (zero, saturated and full counts).",
             beats_sent, PHASES + 1);
    $display("Compared %0d results; %0d mismatched, %0d still owed.",
             results_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS segment_download_allocator");
    end else begin
      $display("FAIL segment_download_allocator");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sda_pkg.sv
rtl/core/sda_div.sv
rtl/core/sda_ctrl.sv
rtl/core/sda_datapath.sv
rtl/core/segment_download_allocator.sv
rtl/core/sda_checker.sv
verif/sda_checker.sv
verif/tb_segment_download_allocator.sv
